// File: rtl/core/hgpc_pkg.sv
// hex grid pixel conversion: fixed-point formats, layout constants and register codes
`timescale 1ns / 1ps

package hgpc_pkg;

	localparam int FRAC_BITS = 8;

	localparam int AX_W    = 16;
	localparam int PIX_W   = 24;
	localparam int RAD_W   = 16;
	localparam int INV_W   = 24;
	localparam int CFG_W   = 24;
	localparam int K_W     = 18;
	localparam int CUBE_SH = 32;

	localparam int HT_W   = 34;
	localparam int HP_W   = HT_W + RAD_W + 1;
	localparam int HEX_SH = PIX_W - FRAC_BITS;
	localparam int HR_W   = HP_W - HEX_SH;

	localparam int PS_W = 40;
	localparam int PR_W = PS_W - FRAC_BITS;
	localparam int PF_W = PR_W + INV_W + 1;
	localparam int FY_W = PF_W + 1;
	localparam int CW   = FY_W - CUBE_SH;

	localparam int PIX_MAX = 2 ** (PIX_W - 1) - 1;
	localparam int AX_MAX  = 2 ** (AX_W - 1) - 1;

	localparam logic signed [K_W-1:0] K_3_2  = 18'sd98304;
	localparam logic signed [K_W-1:0] K_S3_2 = 18'sd56756;
	localparam logic signed [K_W-1:0] K_S3   = 18'sd113512;
	localparam logic signed [K_W-1:0] K_2_3  = 18'sd43691;
	localparam logic signed [K_W-1:0] K_1_3  = 18'sd21845;
	localparam logic signed [K_W-1:0] K_S3_3 = 18'sd37837;

	localparam logic [RAD_W-1:0] RADIUS_RST  = RAD_W'(256);
	localparam logic [INV_W-1:0] INV_RAD_RST = INV_W'(65536);

	typedef enum logic [1:0] {
		CFG_FLAT_TOPPED = 2'd0,
		CFG_RADIUS      = 2'd1,
		CFG_INV_RADIUS  = 2'd2
	} cfg_index_t;

	typedef enum logic {
		CMD_HEX_TO_PIXEL = 1'b0,
		CMD_PIXEL_TO_HEX = 1'b1
	} command_t;

endpackage

// File: rtl/core/hex_grid_pixel_conversion.sv
// hex grid pixel conversion: six-stage pipeline for hex to pixel and pixel to hex
`timescale 1ns / 1ps

// Converts axial hex coordinates to a Q16.8 pixel center (command 0) or a Q16.8 pixel
// position to the nearest axial hex with cube rounding (command 1), flat-topped or
// pointy-topped as the layout register selects. The pipeline has six register stages,
// and out_valid is the valid flag of the last one. A new beat is taken every cycle
// unless a stall from out_ready holds stage 1. The stages are the constant products,
// the radius product or the first rounding, the clamp or the inverse radius product,
// the third cube coordinate, the cube rounding with its errors, and the final selection
// and clamp. Each stage holds its beat while the next one is full and cannot move on,
// so out_ready low stalls only as far back as needed. Registers are written with cfg_we
// and take effect at once; write them only while the pipeline is empty. Results that
// leave their range are clamped and raise saturated.
module hex_grid_pixel_conversion
	import hgpc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [CFG_W-1:0]        cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    command,
	input  logic signed [AX_W-1:0]  hex_q,
	input  logic signed [AX_W-1:0]  hex_r,
	input  logic signed [PIX_W-1:0] pos_x,
	input  logic signed [PIX_W-1:0] pos_y,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [AX_W-1:0]  out_q,
	output logic signed [AX_W-1:0]  out_r,
	output logic signed [PIX_W-1:0] out_x,
	output logic signed [PIX_W-1:0] out_y,
	output logic                    saturated
);

	localparam logic [HEX_SH-1:0]         HEX_HALF = HEX_SH'(1) << (HEX_SH - 1);
	localparam logic [FRAC_BITS-1:0]      PIX_HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);
	localparam logic [CUBE_SH-1:0]        CUBE_HALF = CUBE_SH'(1) << (CUBE_SH - 1);
	localparam logic signed [HR_W-1:0]    XY_MAX = HR_W'(PIX_MAX);
	localparam logic signed [HR_W-1:0]    XY_MIN = ~XY_MAX;
	localparam logic signed [CW-1:0]      QR_MAX = CW'(AX_MAX);
	localparam logic signed [CW-1:0]      QR_MIN = ~QR_MAX;

	// round half away from zero, then clamp to the pixel range; returns {flag, value}
	function automatic logic [PIX_W:0] hex_round_sat(input logic signed [HP_W-1:0] v);
		logic signed [HR_W-1:0] fl;
		logic signed [HR_W-1:0] rv;
		logic [HEX_SH-1:0]      fr;
		logic                   up;
		fl = HR_W'(v >>> HEX_SH);
		fr = v[HEX_SH-1:0];
		up = (fr > HEX_HALF) || ((fr == HEX_HALF) && !v[HP_W-1]);
		rv = fl + HR_W'(up);
		if (rv > XY_MAX) begin
			return {1'b1, XY_MAX[PIX_W-1:0]};
		end else if (rv < XY_MIN) begin
			return {1'b1, XY_MIN[PIX_W-1:0]};
		end
		return {1'b0, rv[PIX_W-1:0]};
	endfunction

	function automatic logic signed [PR_W-1:0] pix_round(input logic signed [PS_W-1:0] v);
		logic signed [PR_W-1:0] fl;
		logic [FRAC_BITS-1:0]   fr;
		logic                   up;
		fl = PR_W'(v >>> FRAC_BITS);
		fr = v[FRAC_BITS-1:0];
		up = (fr > PIX_HALF) || ((fr == PIX_HALF) && !v[PS_W-1]);
		return fl + PR_W'(up);
	endfunction

	// nearest integer and its distance; returns {integer, error}
	function automatic logic [CW+CUBE_SH-1:0] cube_round(input logic signed [FY_W-1:0] v);
		logic [CUBE_SH-1:0] fr;
		logic [CUBE_SH-1:0] err;
		logic signed [CW-1:0] c;
		logic               up;
		fr  = v[CUBE_SH-1:0];
		up  = (fr > CUBE_HALF) || ((fr == CUBE_HALF) && !v[FY_W-1]);
		c   = CW'(v >>> CUBE_SH) + CW'(up);
		err = fr[CUBE_SH-1] ? (~fr + CUBE_SH'(1)) : fr;
		return {c, err};
	endfunction

	function automatic logic [AX_W:0] ax_sat(input logic signed [CW-1:0] v);
		if (v > QR_MAX) begin
			return {1'b1, QR_MAX[AX_W-1:0]};
		end else if (v < QR_MIN) begin
			return {1'b1, QR_MIN[AX_W-1:0]};
		end
		return {1'b0, v[AX_W-1:0]};
	endfunction

	logic             flat_q;
	logic [RAD_W-1:0] radius_q;
	logic [INV_W-1:0] inv_radius_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	logic                   cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5;
	logic signed [PS_W-1:0] a_s1, b_s1;
	logic signed [HP_W-1:0] hx_s2, hy_s2;
	logic signed [PR_W-1:0] pq_s2, pr_s2;
	logic signed [PIX_W-1:0] ox_s3, oy_s3, ox_s4, oy_s4, ox_s5, oy_s5;
	logic                   hsat_s3, hsat_s4, hsat_s5;
	logic signed [PF_W-1:0] fq_s3, fr_s3;
	logic signed [FY_W-1:0] fq_s4, fr_s4, fy_s4;
	logic signed [CW-1:0]   cx_s5, cy_s5, cz_s5;
	logic [CUBE_SH-1:0]     dx_s5, dy_s5, dz_s5;
	logic signed [AX_W-1:0] out_q_s6, out_r_s6;
	logic signed [PIX_W-1:0] out_x_s6, out_y_s6;
	logic                   sat_s6;

	logic signed [PS_W-1:0] qe, re, xe, ye, a_n, b_n;
	logic signed [HP_W-1:0] rad_e, hx_n, hy_n;
	logic signed [PF_W-1:0] inv_e;
	logic [PIX_W:0]         rx_n, ry_n;
	logic [CW+CUBE_SH-1:0]  rcx_n, rcy_n, rcz_n;
	logic                   sel_x, sel_y;
	logic signed [CW-1:0]   cx_f, cz_f;
	logic [AX_W:0]          sq_n, sr_n;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flat_q       <= 1'b1;
			radius_q     <= RADIUS_RST;
			inv_radius_q <= INV_RAD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FLAT_TOPPED: flat_q       <= cfg_wdata[0];
				CFG_RADIUS:      radius_q     <= cfg_wdata[RAD_W-1:0];
				CFG_INV_RADIUS:  inv_radius_q <= cfg_wdata[INV_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv6     = !valid_s6 || out_ready;
	assign adv5     = !valid_s5 || adv6;
	assign adv4     = !valid_s4 || adv5;
	assign adv3     = !valid_s3 || adv4;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
			if (adv5) valid_s5 <= valid_s4;
			if (adv6) valid_s6 <= valid_s5;
		end
	end

	// stage 1: layout constant products
	always_comb begin
		qe = PS_W'(hex_q);
		re = PS_W'(hex_r);
		xe = PS_W'(pos_x);
		ye = PS_W'(pos_y);
		if (command == CMD_HEX_TO_PIXEL) begin
			if (flat_q) begin
				a_n = qe * K_3_2;
				b_n = qe * K_S3_2 + re * K_S3;
			end else begin
				a_n = qe * K_S3 + re * K_S3_2;
				b_n = re * K_3_2;
			end
		end else begin
			if (flat_q) begin
				a_n = xe * K_2_3;
				b_n = ye * K_S3_3 - xe * K_1_3;
			end else begin
				a_n = xe * K_S3_3 - ye * K_1_3;
				b_n = ye * K_2_3;
			end
		end
	end

	// stage 2: radius product, or pixel rounding
	always_comb begin
		rad_e = HP_W'($signed({1'b0, radius_q}));
		hx_n  = HP_W'(HT_W'(a_s1)) * rad_e;
		hy_n  = HP_W'(HT_W'(b_s1)) * rad_e;
	end

	// stage 3: pixel rounding and clamp, or inverse radius product
	always_comb begin
		inv_e = PF_W'($signed({1'b0, inv_radius_q}));
		rx_n  = hex_round_sat(hx_s2);
		ry_n  = hex_round_sat(hy_s2);
	end

	// stage 5: cube rounding
	always_comb begin
		rcx_n = cube_round(fq_s4);
		rcy_n = cube_round(fy_s4);
		rcz_n = cube_round(fr_s4);
	end

	// stage 6: fix the worst rounded component, clamp
	always_comb begin
		sel_x = (dx_s5 > dy_s5) && (dx_s5 > dz_s5);
		sel_y = !sel_x && (dy_s5 > dz_s5);
		cx_f  = sel_x ? (-cy_s5 - cz_s5) : cx_s5;
		cz_f  = (!sel_x && !sel_y) ? (-cx_s5 - cy_s5) : cz_s5;
		sq_n  = ax_sat(cx_f);
		sr_n  = ax_sat(cz_f);
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			cmd_s1 <= command;
			a_s1   <= a_n;
			b_s1   <= b_n;
		end
		if (adv2) begin
			cmd_s2 <= cmd_s1;
			hx_s2  <= hx_n;
			hy_s2  <= hy_n;
			pq_s2  <= pix_round(a_s1);
			pr_s2  <= pix_round(b_s1);
		end
		if (adv3) begin
			cmd_s3  <= cmd_s2;
			ox_s3   <= rx_n[PIX_W-1:0];
			oy_s3   <= ry_n[PIX_W-1:0];
			hsat_s3 <= rx_n[PIX_W] | ry_n[PIX_W];
			fq_s3   <= PF_W'(pq_s2) * inv_e;
			fr_s3   <= PF_W'(pr_s2) * inv_e;
		end
		if (adv4) begin
			cmd_s4  <= cmd_s3;
			ox_s4   <= ox_s3;
			oy_s4   <= oy_s3;
			hsat_s4 <= hsat_s3;
			fq_s4   <= FY_W'(fq_s3);
			fr_s4   <= FY_W'(fr_s3);
			fy_s4   <= -FY_W'(fq_s3) - FY_W'(fr_s3);
		end
		if (adv5) begin
			cmd_s5  <= cmd_s4;
			ox_s5   <= ox_s4;
			oy_s5   <= oy_s4;
			hsat_s5 <= hsat_s4;
			cx_s5   <= rcx_n[CW+CUBE_SH-1:CUBE_SH];
			cy_s5   <= rcy_n[CW+CUBE_SH-1:CUBE_SH];
			cz_s5   <= rcz_n[CW+CUBE_SH-1:CUBE_SH];
			dx_s5   <= rcx_n[CUBE_SH-1:0];
			dy_s5   <= rcy_n[CUBE_SH-1:0];
			dz_s5   <= rcz_n[CUBE_SH-1:0];
		end
		if (adv6) begin
			if (cmd_s5 == CMD_PIXEL_TO_HEX) begin
				out_q_s6 <= sq_n[AX_W-1:0];
				out_r_s6 <= sr_n[AX_W-1:0];
				out_x_s6 <= '0;
				out_y_s6 <= '0;
				sat_s6   <= sq_n[AX_W] | sr_n[AX_W];
			end else begin
				out_q_s6 <= '0;
				out_r_s6 <= '0;
				out_x_s6 <= ox_s5;
				out_y_s6 <= oy_s5;
				sat_s6   <= hsat_s5;
			end
		end
	end

	assign out_valid = valid_s6;
	assign out_q     = out_q_s6;
	assign out_r     = out_r_s6;
	assign out_x     = out_x_s6;
	assign out_y     = out_y_s6;
	assign saturated = sat_s6;

endmodule
